/* hw/rtl/mfe_pkg.sv */
// Shared types and constants for the framed Manchester encoder.
package mfe_pkg;

  // Field and bus widths fixed by the stream format
  localparam int VALUE_W     = 10;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 8;

  // Defaults for the top-level parameters
  localparam int DATA_BITS_DEF   = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Frame preamble: 1,1,1,0
  localparam int SYNC_BITS = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYNC,
    ST_DATA,
    ST_STUFF,
    ST_TRAIL
  } mfe_state_t;

endpackage

/* hw/rtl/mfe_front.sv */
// Input stage: takes words from the slave stream, keeps the data bits, feeds the queue.
module mfe_front import mfe_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] value
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [DATA_BITS-1:0] q_word
);

  logic                 hold_valid;
  logic                 hold_valid_next;
  logic [DATA_BITS-1:0] hold_word;
  logic                 accept;

  assign s_tready = !hold_valid || q_ready;
  assign accept   = s_tvalid && s_tready;
  assign q_valid  = hold_valid;
  assign q_word   = hold_word;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (hold_valid && q_ready) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  // bits at or above DATA_BITS are dropped, missing ones read as zero
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_word <= DATA_BITS'(s_tdata[VALUE_W-1:0]);
    end
  end

endmodule

/* hw/rtl/mfe_queue.sv */
// Small word queue between the input stage and the line sequencer.
module mfe_queue import mfe_pkg::*; #(
  parameter int WIDTH = DATA_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_pop,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

/* hw/rtl/mfe_back.sv */
// Line sequencer: sync, data, stuffed and trailing bits as half-bit levels.
module mfe_back import mfe_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic [DATA_BITS-1:0] q_word,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [0] line_level, rest zero
  output logic                 m_tlast
);

  localparam int CW  = $clog2(DATA_BITS + 1);
  localparam int SCW = $clog2(SYNC_BITS);

  mfe_state_t           state, state_next;
  logic [DATA_BITS-1:0] word, word_next;
  logic [CW-1:0]        cnt, cnt_next;        // data bits not yet sent
  logic [SCW-1:0]       sync_cnt, sync_cnt_next;
  logic                 run, run_next;        // one '1' pending
  logic                 half, half_next;
  logic                 out_valid, out_valid_next;
  logic                 out_level, out_level_next;
  logic                 out_last, out_last_next;

  logic out_free;
  logic adv;
  logic cur_bit;
  logic last_bit;

  assign out_free = !out_valid || m_tready;
  assign adv      = (state != ST_IDLE) && out_free;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_level);
  assign m_tlast  = out_last;

  always_comb begin
    cur_bit  = 1'b0;
    last_bit = 1'b0;
    case (state)
      ST_SYNC: begin
        cur_bit = (sync_cnt != SCW'(SYNC_BITS - 1));
      end
      ST_DATA: begin
        cur_bit  = word[DATA_BITS-1];
        last_bit = (cnt == CW'(1)) && !word[DATA_BITS-1];
      end
      ST_STUFF: begin
        last_bit = (cnt == '0);
      end
      ST_TRAIL: begin
        last_bit = 1'b1;
      end
      default: begin
        cur_bit  = 1'b0;
        last_bit = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    word_next      = word;
    cnt_next       = cnt;
    sync_cnt_next  = sync_cnt;
    run_next       = run;
    half_next      = half;
    out_valid_next = out_valid;
    out_level_next = out_level;
    out_last_next  = out_last;

    if (adv) begin
      out_valid_next = 1'b1;
      out_level_next = half ? cur_bit : !cur_bit;
      out_last_next  = half && last_bit;
      half_next      = !half;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          word_next     = q_word;
          cnt_next      = CW'(DATA_BITS);
          sync_cnt_next = '0;
          run_next      = 1'b0;
          half_next     = 1'b0;
          state_next    = ST_SYNC;
        end
      end
      ST_SYNC: begin
        if (adv && half) begin
          sync_cnt_next = sync_cnt + 1'b1;
          if (sync_cnt == SCW'(SYNC_BITS - 1)) begin
            state_next = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (adv && half) begin
          word_next = word << 1;
          cnt_next  = cnt - 1'b1;
          if (cur_bit && run) begin
            run_next   = 1'b0;
            state_next = ST_STUFF;
          end else begin
            run_next = cur_bit;
            if (cnt == CW'(1)) begin
              state_next = cur_bit ? ST_TRAIL : ST_IDLE;
            end
          end
        end
      end
      ST_STUFF: begin
        if (adv && half) begin
          state_next = (cnt == '0) ? ST_IDLE : ST_DATA;
        end
      end
      ST_TRAIL: begin
        if (adv && half) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      half      <= 1'b0;
      out_valid <= 1'b0;
      sync_cnt  <= '0;
      run       <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      half      <= half_next;
      out_valid <= out_valid_next;
      sync_cnt  <= sync_cnt_next;
      run       <= run_next;
      cnt       <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    word      <= word_next;
    out_level <= out_level_next;
    out_last  <= out_last_next;
  end

endmodule

/* hw/rtl/manchester_frame_encoder_unit.sv */
// Top level of the framed Manchester encoder: input stage, word queue, line sequencer.
// A word passes the front register, the queue and the sequencer state before m_tvalid.
// Throughput: one half-bit per cycle while m_tready is high, 2*(4+DATA_BITS) to
//   2*(4+DATA_BITS+(DATA_BITS+1)/2) half-bits per word (28..38 at DATA_BITS=10), plus
//   an IDLE state in the sequencer to load the next word; the sequencer's one-half-bit-per-cycle output sets this.
// Reset: rst (sync, high) empties the queue and drops any frame in flight.
module manchester_frame_encoder_unit import mfe_pkg::*; #(
  parameter int DATA_BITS   = DATA_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // word stream in
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] value, [15:10] zero fill
  // half-bit stream out
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [0] line_level, [7:1] zero fill
  output logic                 m_tlast    // last half-bit of the frame
);

  // front stage -> queue
  logic                 fq_valid;
  logic                 fq_ready;
  logic [DATA_BITS-1:0] fq_word;

  // queue -> sequencer
  logic                 qb_valid;
  logic                 qb_pop;
  logic [DATA_BITS-1:0] qb_word;

  // Front: registers the incoming word and trims it to DATA_BITS
  mfe_front #(
    .DATA_BITS (DATA_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_word   (fq_word)
  );

  // Queue: lets new words arrive while a frame is still going out
  mfe_queue #(
    .WIDTH (DATA_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_word),
    .out_valid (qb_valid),
    .out_pop   (qb_pop),
    .out_data  (qb_word)
  );

  // Back: walks sync, data (MSB first), stuffed zeros after each pair of ones,
  // and a closing zero if a lone one is pending; each line bit is two
  // half-bits (one = low,high; zero = high,low) through an output register.
  mfe_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_pop    (qb_pop),
    .q_word   (qb_word),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
